@@ src/mm64_pkg.sv @@
// shared types, constants and helpers of the murmurhash64a stream hasher
package mm64_pkg;

  localparam logic [63:0] MIX_MULT  = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_SHIFT = 47;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_PART,
    KIND_FULL
  } word_kind_e;

  typedef struct packed {
    logic [63:0] word;
    logic [63:0] length;
    word_kind_e  kind;
    logic        first;
    logic        last;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EMIT
  } back_state_e;

  typedef enum logic [2:0] {
    PH_LEN,
    PH_K1,
    PH_K2,
    PH_H,
    PH_FIN
  } mul_phase_e;

  typedef struct packed {
    logic busy;
    logic pop;
  } back_stat_t;

  function automatic logic [63:0] xorshift(input logic [63:0] v);
    return v ^ (v >> MIX_SHIFT);
  endfunction

endpackage

@@ src/mm64_front.sv @@
// front end: takes words, classifies them and masks partial words
module mm64_front (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [63:0]          data_word_i,
  input  logic [3:0]           byte_count_i,
  input  logic                 first_word_i,
  input  logic                 last_word_i,
  input  logic [63:0]          message_length_i,
  input  logic                 q_ready_i,
  output logic                 push_o,
  output mm64_pkg::item_t      item_o
);
  import mm64_pkg::*;

  logic [63:0] masked;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      masked[i*8 +: 8] = (4'(i) < byte_count_i) ? data_word_i[i*8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    item_o.word   = masked;
    item_o.length = message_length_i;
    item_o.first  = first_word_i;
    item_o.last   = last_word_i;
    // counts above eight count as a full word
    if (byte_count_i == 4'd0) begin
      item_o.kind = KIND_NONE;
    end else if (byte_count_i >= 4'd8) begin
      item_o.kind = KIND_FULL;
      item_o.word = data_word_i;
    end else begin
      item_o.kind = KIND_PART;
    end
  end

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;

endmodule

@@ src/mm64_fifo.sv @@
// small queue of classified words between front and back
module mm64_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mm64_pkg::item_t item_i,
  output logic            ready_o,
  output logic            valid_o,
  output mm64_pkg::item_t item_o,
  input  logic            pop_i
);
  import mm64_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign ready_o = (count_q != CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ src/mm64_back.sv @@
// back end: sequencer around one shared 32x32 multiplier, running hash and result register
module mm64_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [63:0]          seed_i,
  input  logic                 item_valid_i,
  input  mm64_pkg::item_t      item_i,
  output mm64_pkg::back_stat_t stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [63:0]          hash_value_o
);
  import mm64_pkg::*;

  typedef struct packed {
    logic        go;
    mul_phase_e  phase;
    logic [63:0] opnd;
  } mul_plan_t;

  localparam logic [1:0] STEP_LO      = 2'd0;
  localparam logic [1:0] STEP_CROSS_A = 2'd1;
  localparam logic [1:0] STEP_CROSS_B = 2'd2;

  back_state_e state_q, state_d;
  mul_phase_e  phase_q;
  logic [1:0]  step_q;
  logic [63:0] opa_q, acc_q, acc_d;
  logic [63:0] h_q, h_d;
  logic        h_we;
  item_t       ent_q;
  logic [63:0] res_q;
  logic        out_valid_q;
  logic [63:0] out_hash_q;

  logic        pop, mul_done, fin_done, load_out;
  mul_plan_t   plan;
  logic [31:0] mx, my;
  logic [63:0] prod;
  logic [31:0] hi_sum;
  logic [63:0] product;

  // next multiply after the optional initial load
  function automatic mul_plan_t fold_plan(input logic [63:0] h, input item_t e);
    mul_plan_t p;
    p.go    = 1'b0;
    p.phase = PH_FIN;
    p.opnd  = h;
    case (e.kind)
      KIND_FULL: begin
        p.go    = 1'b1;
        p.phase = PH_K1;
        p.opnd  = e.word;
      end
      KIND_PART: begin
        p.go    = 1'b1;
        p.phase = PH_H;
        p.opnd  = h ^ e.word;
      end
      default: begin
        p.go    = e.last;
        p.phase = PH_FIN;
        p.opnd  = xorshift(h);
      end
    endcase
    return p;
  endfunction

  // one partial product a cycle: lo*lo, then the two cross terms into the upper half
  always_comb begin
    case (step_q)
      STEP_LO: begin
        mx = opa_q[31:0];
        my = MIX_MULT[31:0];
      end
      STEP_CROSS_A: begin
        mx = opa_q[31:0];
        my = MIX_MULT[63:32];
      end
      default: begin
        mx = opa_q[63:32];
        my = MIX_MULT[31:0];
      end
    endcase
    prod    = {32'h0, mx} * {32'h0, my};
    hi_sum  = acc_q[63:32] + prod[31:0];
    product = {hi_sum, acc_q[31:0]};
    acc_d   = (step_q == STEP_LO) ? prod : product;
  end

  // outputs of the sequencer
  always_comb begin
    pop      = (state_q == ST_IDLE) && item_valid_i;
    mul_done = (state_q == ST_MUL) && (step_q == STEP_CROSS_B);
    fin_done = mul_done && (phase_q == PH_FIN);
    load_out = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  end

  // datapath plan: what the next multiply works on and how the hash moves
  always_comb begin
    plan.go    = 1'b0;
    plan.phase = PH_FIN;
    plan.opnd  = product;
    h_we       = 1'b0;
    h_d        = product;
    if (pop) begin
      if (item_i.first) begin
        plan.go    = 1'b1;
        plan.phase = PH_LEN;
        plan.opnd  = item_i.length;
      end else begin
        plan = fold_plan(h_q, item_i);
      end
    end else if (mul_done) begin
      case (phase_q)
        PH_LEN: begin
          h_we = 1'b1;
          h_d  = seed_i ^ product;
          plan = fold_plan(seed_i ^ product, ent_q);
        end
        PH_K1: begin
          plan.go    = 1'b1;
          plan.phase = PH_K2;
          plan.opnd  = xorshift(product);
        end
        PH_K2: begin
          plan.go    = 1'b1;
          plan.phase = PH_H;
          plan.opnd  = h_q ^ product;
        end
        PH_H: begin
          h_we       = 1'b1;
          h_d        = product;
          plan.go    = ent_q.last;
          plan.phase = PH_FIN;
          plan.opnd  = xorshift(product);
        end
        default: begin
          plan.go = 1'b0;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop && plan.go) state_d = ST_MUL;
      end
      ST_MUL: begin
        if (fin_done) begin
          state_d = ST_EMIT;
        end else if (mul_done && !plan.go) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_LEN;
      step_q      <= STEP_LO;
      h_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (plan.go) begin
        phase_q <= plan.phase;
        step_q  <= STEP_LO;
      end else if (state_q == ST_MUL && !mul_done) begin
        step_q <= step_q + 1'b1;
      end
      if (h_we) h_q <= h_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop)            ent_q <= item_i;
    if (plan.go)        opa_q <= plan.opnd;
    if (state_q == ST_MUL) acc_q <= acc_d;
    if (fin_done)       res_q <= xorshift(product);
    if (load_out)       out_hash_q <= res_q;
  end

  assign stat_o.busy  = (state_q != ST_IDLE);
  assign stat_o.pop   = pop;
  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_hash_q;

endmodule

@@ src/murmur2_64_hash_stream.sv @@
// top level of the murmurhash64a stream hasher
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, data_word_i, byte_count_i, | to block
//          | first_word_i, last_word_i, message_length_i      |
//  out     | out_valid_o/out_ready_i, hash_value_o            | from block
//  cfg     | cfg_valid_i/cfg_ready_o, hash_seed_i             | to block
//
// multiplier: one 32x32 multiplier is shared; each 64-bit multiply by the mix constant
//   is built from the low product plus two cross terms. a word leaves the queue, then
//   takes one multiply for the length on a first word, three for a full word, one for
//   a partial word, and one more plus the result load for a last word
// reset: clears the seed, the running hash, the queue and the result valid flag
// stalls: the queue lets the front take words while the back works; a stalled
//   result holds the back in its emit state, and the queue then fills up
module murmur2_64_hash_stream #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        first_word_i,
  input  logic        last_word_i,
  input  logic [63:0] message_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] hash_value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] hash_seed_i
);
  import mm64_pkg::*;

  logic [63:0] seed_q;
  logic        q_ready, q_push, q_valid;
  item_t       push_item, pop_item;
  back_stat_t  back_stat;

  // seed register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_valid_i) begin
      seed_q <= hash_seed_i;
    end
  end

  // front: classify by byte count and mask partial words
  mm64_front u_front (
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_word_i      (data_word_i),
    .byte_count_i     (byte_count_i),
    .first_word_i     (first_word_i),
    .last_word_i      (last_word_i),
    .message_length_i (message_length_i),
    .q_ready_i        (q_ready),
    .push_o           (q_push),
    .item_o           (push_item)
  );

  // queue decoupling front and back
  mm64_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (pop_item),
    .pop_i   (back_stat.pop)
  );

  // back: multiply sequencer, running hash, finalization and result register
  mm64_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_i       (seed_q),
    .item_valid_i (q_valid),
    .item_i       (pop_item),
    .stat_o       (back_stat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o)
  );

  // back only takes a word the queue actually holds
  a_pop_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.pop |-> q_valid)
    else $error("queue popped while empty");

  // a busy back never takes another word
  a_no_pop_when_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.busy |-> !back_stat.pop)
    else $error("word taken while back busy");

  // a new result only comes out of back work
  a_result_from_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(back_stat.busy))
    else $error("result appeared without back activity");

endmodule

@@ tb/sv/tb.sv @@
// testbench for the murmurhash64a stream hasher: self-checking, random stalls on both sides
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mm64_pkg::*;

  // cycles without any handshake before the run is declared hung; set far above the
  // slowest word, the longest stall of the sender or the receiver and the pause
  // that a seed write waits out, so this is far above any legal stretch
  localparam int unsigned HANG_LIMIT    = 3000;
  // quiet cycles that let words with no hash drain out of the block's queue
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned RANDOM_WORDS  = 400;
  localparam int unsigned NUM_PHASES    = 6;

  // predicts the hash of every completed message and checks the block's output
  class hash_checker;
    logic [63:0] seed;
    logic [63:0] run_hash;
    logic [63:0] pending_hashes[$];
    int unsigned words_taken;
    int unsigned hashes_checked;
    int unsigned seeds_taken;
    int unsigned errors;

    function new();
      seed           = '0;
      run_hash       = '0;
      words_taken    = 0;
      hashes_checked = 0;
      seeds_taken    = 0;
      errors         = 0;
    endfunction

    // two multiplies around a 47-bit xor-shift
    function logic [63:0] scramble(logic [63:0] k);
      k = k * MIX_MULT;
      k = k ^ (k >> MIX_SHIFT);
      k = k * MIX_MULT;
      return k;
    endfunction

    function logic [63:0] finish_hash(logic [63:0] h);
      h = h ^ (h >> MIX_SHIFT);
      h = h * MIX_MULT;
      h = h ^ (h >> MIX_SHIFT);
      return h;
    endfunction

    function void take_seed(logic [63:0] value);
      seed = value;
      seeds_taken++;
    endfunction

    function void take_word(logic [63:0] word, logic [3:0] count, logic first,
                            logic last, logic [63:0] length);
      word_kind_e  kind;
      logic [63:0] h;
      logic [63:0] mask;
      h = run_hash;
      if (first) begin
        h = seed ^ (length * MIX_MULT);
      end
      if (count >= 4'd8) begin
        kind = KIND_FULL;
      end else if (count != 4'd0) begin
        kind = KIND_PART;
      end else begin
        kind = KIND_NONE;
      end
      case (kind)
        KIND_FULL: begin
          h = (h ^ scramble(word)) * MIX_MULT;
        end
        KIND_PART: begin
          mask = (64'h1 << (8 * int'(count))) - 64'h1;
          h = (h ^ (word & mask)) * MIX_MULT;
        end
        default: begin
        end
      endcase
      // the finalization does not feed back into the running hash
      run_hash = h;
      if (last) begin
        pending_hashes = {pending_hashes, finish_hash(h)};
      end
      words_taken++;
    endfunction

    function void check_hash(logic [63:0] actual);
      logic [63:0] wanted;
      if (pending_hashes.size() == 0) begin
        $display("%0t: hash_value %h with no hash expected", $time, actual);
        errors++;
      end else begin
        wanted = pending_hashes.pop_front();
        if (actual !== wanted) begin
          $display("%0t: hash_value mismatch, expected %h, actual %h", $time, wanted, actual);
          errors++;
        end
        hashes_checked++;
      end
    endfunction

    function int unsigned pending_count();
      return pending_hashes.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [63:0] data_word_i;
  logic [3:0]  byte_count_i;
  logic        first_word_i;
  logic        last_word_i;
  logic [63:0] message_length_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] hash_value_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [63:0] hash_seed_i;

  hash_checker hashes;
  int unsigned quiet_cycles;
  // per-message and per-stretch switches that turn the sender's or receiver's gaps off
  logic        tx_steady;
  logic        rx_steady;

  murmur2_64_hash_stream u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_word_i     (data_word_i),
    .byte_count_i    (byte_count_i),
    .first_word_i    (first_word_i),
    .last_word_i     (last_word_i),
    .message_length_i(message_length_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hash_value_o    (hash_value_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .hash_seed_i     (hash_seed_i)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // monitors: all handshakes are sampled at the rising edge, before any
  // nonblocking update of that edge lands, so the order of processes does not matter
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        hashes.take_seed(hash_seed_i);
      end
      if (in_valid_i && in_ready_o) begin
        hashes.take_word(data_word_i, byte_count_i, first_word_i, last_word_i,
                         message_length_i);
      end
      if (out_valid_o && out_ready_i) begin
        hashes.check_hash(hash_value_o);
      end
    end
  end

  // watchdog: any handshake restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d hashes outstanding", $time,
               quiet_cycles, hashes.pending_count());
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stall before each hash, with stretches of none
  initial begin
    int unsigned gap;
    out_ready_i <= 1'b0;
    rx_steady   = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) begin
        rx_steady = !rx_steady;
      end
      gap = rx_steady ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // one word on the input channel; valid stays high after acceptance so that a
  // back-to-back word does not drop it for a single step
  task automatic send_word(input logic [63:0] word, input logic [3:0] count,
                           input logic first, input logic last,
                           input logic [63:0] length);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    data_word_i      <= word;
    byte_count_i     <= count;
    first_word_i     <= first;
    last_word_i      <= last;
    message_length_i <= length;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // a whole message of nbytes bytes; drop_last leaves it unterminated
  task automatic send_message(input int unsigned nbytes, input logic [63:0] length,
                              input logic drop_last, inout int unsigned sent);
    int unsigned nwords;
    int unsigned left;
    logic [3:0]  count;
    nwords = (nbytes == 0) ? 1 : (nbytes + 7) / 8;
    left   = nbytes;
    for (int unsigned i = 0; i < nwords; i++) begin
      count = (left >= 8) ? 4'd8 : 4'(left);
      // a full word is sometimes flagged with a count above eight
      if (count == 4'd8 && $urandom_range(0, 7) == 0) begin
        count = 4'($urandom_range(9, 15));
      end
      send_word(rand_word(), count, i == 0, (i == nwords - 1) && !drop_last, length);
      left = (left >= 8) ? left - 8 : 0;
      sent++;
    end
  endtask

  // hand-picked corner words; run right after reset
  task automatic run_directed();
    tx_steady = 1'b0;
    // continuation straight after reset starts from a zero running hash
    send_word(64'h0123_4567_89ab_cdef, 4'd8, 1'b0, 1'b1, 64'd0);
    // empty message
    send_word('0, 4'd0, 1'b1, 1'b1, 64'd0);
    // single full words at the data extremes
    send_word('1, 4'd8, 1'b1, 1'b1, 64'd8);
    send_word('0, 4'd8, 1'b1, 1'b1, 64'd8);
    // counts above eight saturate to a full word; largest length
    send_word('1, 4'd15, 1'b1, 1'b1, '1);
    send_word(64'h8000_0000_0000_0001, 4'd9, 1'b1, 1'b1, 64'h8000_0000_0000_0000);
    // every partial count, with junk in the unused bytes
    for (int i = 1; i < 8; i++) begin
      send_word('1, 4'(i), 1'b1, 1'b1, 64'(i));
    end
    // multi-word message with a partial word in the middle and an empty last word
    send_word(64'hdead_beef_cafe_f00d, 4'd8, 1'b1, 1'b0, 64'd19);
    send_word(64'hffff_ffff_ff12_3456, 4'd3, 1'b0, 1'b0, '1);
    send_word(64'h1111_2222_3333_4444, 4'd8, 1'b0, 1'b0, 64'd0);
    send_word('1, 4'd0, 1'b0, 1'b1, 64'd0);
    // words after a finalized message continue the unfinalized hash
    send_word(64'h5a5a_a5a5_5a5a_a5a5, 4'd8, 1'b0, 1'b1, 64'd0);
    send_word(64'h0f0f_0f0f_0f0f_0f0f, 4'd5, 1'b0, 1'b1, 64'd0);
    // first word with nothing to fold in, then a partial last word
    send_word('1, 4'd0, 1'b1, 1'b0, 64'd5);
    send_word(64'h0000_00ab_cdef_0123, 4'd5, 1'b0, 1'b1, 64'd5);
    // first and last on the same partial word, length disagreeing
    send_word(64'h7777_7777_7777_7777, 4'd4, 1'b1, 1'b1, 64'd1000);
  endtask

  // seeds are only written once every hash has come back and stray words
  // without a hash have had time to drain
  task automatic write_seed(input logic [63:0] value);
    while (hashes.pending_count() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    hash_seed_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned sent;
    int unsigned pick;
    int unsigned nbytes;
    logic [63:0] length;
    sent = 0;
    while (sent < target) begin
      tx_steady = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        // well-formed message, mostly short
        if ($urandom_range(0, 9) < 7) begin
          nbytes = $urandom_range(0, 24);
        end else begin
          nbytes = $urandom_range(25, 72);
        end
        length = ($urandom_range(0, 9) == 0) ? {$urandom(), $urandom()} : 64'(nbytes);
        send_message(nbytes, length, 1'b0, sent);
      end else if (pick < 90) begin
        // truncated message: no last word
        nbytes = $urandom_range(1, 24);
        send_message(nbytes, 64'(nbytes), 1'b1, sent);
      end else begin
        // noise: every field random
        send_word({$urandom(), $urandom()}, 4'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  {$urandom(), $urandom()});
        sent++;
      end
    end
  endtask

  initial begin
    logic [63:0] seeds[NUM_PHASES];
    hashes           = new();
    tx_steady        = 1'b0;
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    data_word_i      <= '0;
    byte_count_i     <= '0;
    first_word_i     <= 1'b0;
    last_word_i      <= 1'b0;
    message_length_i <= '0;
    cfg_valid_i      <= 1'b0;
    hash_seed_i      <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // phase 0 runs on the reset seed; the others write it
    seeds[0] = '0;
    seeds[1] = '1;
    seeds[2] = '0;
    seeds[3] = {$urandom(), $urandom()};
    seeds[4] = 64'h1;
    seeds[5] = 64'h8000_0000_0000_0000;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        write_seed(seeds[p]);
      end
      if (p == 0) begin
        run_directed();
      end
      run_random(RANDOM_WORDS / NUM_PHASES);
      in_valid_i <= 1'b0;
    end

    // drain, then watch for stray hashes a little longer
    while (hashes.pending_count() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d words and %0d hashes over %0d seed settings (%0d seed writes)",
             hashes.words_taken, hashes.hashes_checked, NUM_PHASES, hashes.seeds_taken);
    $display("%0d mismatches, %0d hashes left unmatched", hashes.errors,
             hashes.pending_count());
    if (hashes.errors == 0 && hashes.pending_count() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/mm64_pkg.sv
src/mm64_front.sv
src/mm64_fifo.sv
src/mm64_back.sv
src/murmur2_64_hash_stream.sv
tb/sv/tb.sv
